### hw/rtl/four_level_page_walk_assert.svh
// ----------------------------------------------------------------------------
// four_level_page_walk assertion macros
// shared concurrent assertion forms for the page walker
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_WALK_ASSERT_SVH
`define FOUR_LEVEL_PAGE_WALK_ASSERT_SVH

// same-cycle implication
`define FLPW_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flpw assertion failed");

// next-cycle implication
`define FLPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flpw assertion failed");

`endif

### hw/rtl/flpw_pkg.sv
// ----------------------------------------------------------------------------
// flpw_pkg
// types, constants and helpers shared by the page walker modules
// ----------------------------------------------------------------------------
package flpw_pkg;

    localparam int FRAME_COUNT     = 16;
    localparam int INDEX_BITS      = 9;
    localparam int WORDS_PER_FRAME = 1 << INDEX_BITS;
    localparam int MEM_WORDS       = FRAME_COUNT * WORDS_PER_FRAME;
    localparam int FRAME_W         = $clog2(FRAME_COUNT);
    localparam int MEM_ADDR_W      = FRAME_W + INDEX_BITS;
    localparam int ENTRY_W         = 64;
    localparam int VA_W            = 48;
    localparam int WIDX_W          = 13;
    localparam int ROOT_W          = 4;
    localparam int NEXT_FRAME_W    = 40;
    localparam int LEVEL_W         = 2;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(3);

    // register word index on the apb port
    localparam logic [0:0] REG_ROOT_FRAME = 1'b0;

    typedef enum logic {
        ACT_WRITE     = 1'b0,
        ACT_TRANSLATE = 1'b1
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_walk_state;

    typedef struct packed {
        logic                  action;
        logic [WIDX_W-1:0]     word_index;
        logic [ENTRY_W-1:0]    word_data;
        logic [VA_W-1:0]       virtual_address;
    } t_cmd;

    typedef struct packed {
        logic [ENTRY_W-1:0]    leaf_entry;
        logic                  mapped;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [MEM_ADDR_W-1:0] waddr;
        logic [ENTRY_W-1:0]    wdata;
        logic [MEM_ADDR_W-1:0] raddr;
    } t_mem_req;

    // table index for one walk level
    function automatic logic [INDEX_BITS-1:0] va_index(
        input logic [VA_W-1:0]    va,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [INDEX_BITS-1:0] idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

### hw/rtl/flpw_table_ram.sv
// ----------------------------------------------------------------------------
// flpw_table_ram
// page table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module flpw_table_ram
    import flpw_pkg::*;
(
    input  logic               i_clk,
    input  t_mem_req           i_req,
    output logic [ENTRY_W-1:0] o_rd_data
);

    logic [ENTRY_W-1:0] r_mem [MEM_WORDS];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/flpw_walker.sv
// ----------------------------------------------------------------------------
// flpw_walker
// command decode and four-level walk sequencer over the table memory
// ----------------------------------------------------------------------------
`include "four_level_page_walk_assert.svh"

module flpw_walker
    import flpw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_cmd               i_cmd,
    input  logic [ROOT_W-1:0]  i_root_frame,
    input  logic [ENTRY_W-1:0] i_rd_data,
    output logic               o_busy,
    output logic               o_done,
    output t_result            o_result,
    output t_mem_req           o_mem_req
);

    t_walk_state              r_state,  n_state;
    logic [LEVEL_W-1:0]       r_level,  n_level;
    logic [FRAME_W-1:0]       r_frame,  n_frame;
    logic [VA_W-1:0]          r_va,     n_va;
    logic                     r_done,   n_done;
    t_result                  r_result, n_result;

    logic                     accept;
    logic                     root_ok;
    logic                     next_ok;
    logic [NEXT_FRAME_W-1:0]  next_frame;

    assign accept     = i_start && (r_state == ST_IDLE);
    assign root_ok    = NEXT_FRAME_W'(i_root_frame) < NEXT_FRAME_W'(FRAME_COUNT);
    assign next_frame = i_rd_data[51:12];
    assign next_ok    = next_frame < NEXT_FRAME_W'(FRAME_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_level <= '0;
            r_frame <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            r_frame <= n_frame;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va     <= n_va;
        r_result <= n_result;
    end

    always_comb begin
        n_state         = r_state;
        n_level         = r_level;
        n_frame         = r_frame;
        n_va            = r_va;
        n_done          = 1'b0;
        n_result        = r_result;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = MEM_ADDR_W'(i_cmd.word_index);
        o_mem_req.wdata = i_cmd.word_data;
        o_mem_req.raddr = {r_frame, va_index(r_va, r_level)};

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd.action == ACT_WRITE) begin
                        o_mem_req.we = 32'(i_cmd.word_index) < 32'(MEM_WORDS);
                    end else begin
                        n_va    = i_cmd.virtual_address;
                        n_level = '0;
                        if (root_ok) begin
                            n_frame         = FRAME_W'(i_root_frame);
                            n_state         = ST_WALK;
                            o_mem_req.raddr = {FRAME_W'(i_root_frame),
                                               va_index(i_cmd.virtual_address, '0)};
                        end else begin
                            n_done   = 1'b1;
                            n_result = '0;
                        end
                    end
                end
            end
            ST_WALK: begin
                if (!i_rd_data[0]) begin
                    n_done   = 1'b1;
                    n_result = '0;
                    n_state  = ST_IDLE;
                end else if (r_level == LAST_LEVEL) begin
                    n_done              = 1'b1;
                    n_result.leaf_entry = i_rd_data;
                    n_result.mapped     = 1'b1;
                    n_state             = ST_IDLE;
                end else if (!next_ok) begin
                    n_done   = 1'b1;
                    n_result = '0;
                    n_state  = ST_IDLE;
                end else begin
                    n_level         = r_level + LEVEL_W'(1);
                    n_frame         = FRAME_W'(next_frame);
                    o_mem_req.raddr = {FRAME_W'(next_frame),
                                       va_index(r_va, r_level + LEVEL_W'(1))};
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    `FLPW_ASSERT_NEXT(a_walk_starts, i_clk, i_rst_n,
        accept && i_cmd.action == ACT_TRANSLATE && root_ok, o_busy)
    `FLPW_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, accept && i_cmd.action == ACT_WRITE, !r_done)
    `FLPW_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, r_done, r_state == ST_IDLE)
    `FLPW_ASSERT_IMPLY(a_unmapped_zero, i_clk, i_rst_n,
        r_done && !r_result.mapped, r_result.leaf_entry == '0)

endmodule

### hw/rtl/four_level_page_walk.sv
// ----------------------------------------------------------------------------
// four_level_page_walk
// four-level page table walker over a local table memory
//
//   port group     direction  handshake          word
//   command        in         start / busy       t_cmd
//   result         out        o_done strobe      t_result
//   configuration  in/out     apb, pready high   root_frame at byte 0
//
// a table write is taken at the accepting edge and gives no result
// a full translation makes four dependent table reads, the first issued in
// the accepting cycle, and registers the leaf entry from the last one
// a walk stopped by a missing entry at level 0 to 3 or by an out-of-range
// next frame at level 0 to 2 gives its result once that level's entry is read
// a failed root check gives the result on the cycle after start
// busy holds off commands while a walk runs; synchronous active-low reset
// clears control and root_frame, not the memory; the receiver cannot stall
// ----------------------------------------------------------------------------
module four_level_page_walk
    import flpw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [ROOT_W-1:0]  r_root_frame;
    logic               cfg_wr;
    logic               reg_sel;
    logic [ENTRY_W-1:0] rd_data;
    t_mem_req           mem_req;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_ROOT_FRAME);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_frame <= '0;
        end else if (cfg_wr) begin
            r_root_frame <= pwdata[ROOT_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(r_root_frame) : '0;

    flpw_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (i_cmd),
        .i_root_frame (r_root_frame),
        .i_rd_data    (rd_data),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_result     (o_result),
        .o_mem_req    (mem_req)
    );

    flpw_table_ram u_table_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

endmodule
